// File: design/pba_pkg.sv
// Shared constants, status codes and controller command type for the page bitmap allocator.
package pba_pkg;

    localparam int ADDR_W          = 48;
    localparam int WORD_BITS       = 64;
    localparam int WORD_BIT_W      = 6;
    localparam int PAGE_COUNT_DEF  = 512;
    localparam int PAGE_SIZE_DEF   = 4096;
    localparam logic [ADDR_W-1:0] BASE_RESET = 48'h00_0000_40_0000;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_PAGE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
    } cmd_t;

    // Lowest clear bit of a bitmap word (0 if the word is full; caller checks).
    function automatic logic [WORD_BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = WORD_BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: design/page_bitmap_allocator_top.sv
// Top level of the first-fit page bitmap allocator.
// A request transfers at a rising edge with start high and busy low; func 0 allocates the
// lowest free page and returns base_address + index * PAGE_SIZE, func 1 frees the page at
// free_address. Every request runs through capture (summary encode or free offset
// check), bitmap word read from the word memory, then update and result. The result is
// valid for exactly one cycle with done high, in the first cycle with busy low again, and
// cannot be held off by the receiver; a new request may transfer in that same cycle. status
// is 0 ok, 1 no free page, 2 misaligned or out-of-range free (ignored). Freeing an already
// free page reports ok. The bitmap is empty after reset with no clearing pass: per-word
// valid bits stand in for the cleared memory. base_address resets to 0x400000 and is
// written through the cfg channel (cfg_ready is always high); write it only while no
// request is in flight.
module page_bitmap_allocator_top #(
    parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SIZE  = pba_pkg::PAGE_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         func,
    input  logic [pba_pkg::ADDR_W-1:0]   free_address,
    output logic                         done,
    output logic [pba_pkg::ADDR_W-1:0]   page_address,
    output logic [1:0]                   status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pba_pkg::ADDR_W-1:0]   cfg_data
);

    pba_pkg::cmd_t cmd;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    pba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    pba_dp #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SIZE  (PAGE_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .free_address (free_address),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .page_address (page_address),
        .status       (status),
        .done         (done)
    );

endmodule

// File: design/pba_ctrl.sv
// Controller state machine: sequences capture, bitmap read and update for one request.
module pba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output pba_pkg::cmd_t   cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:  state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.read    = (state_reg == S_LOOK);
    assign cmd.update  = (state_reg == S_UPD);

    a_upd_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |=> (state_reg == S_IDLE))
        else $error("update state did not return to idle");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_LOOK))
        else $error("accepted request did not enter lookup");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.read, cmd.update}))
        else $error("more than one datapath command active");

endmodule

// File: design/pba_dp.sv
// Datapath: base register, bitmap word memory, full summary, encoders and result register.
module pba_dp #(
    parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SIZE  = pba_pkg::PAGE_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pba_pkg::cmd_t                cmd,
    input  logic                         func,
    input  logic [pba_pkg::ADDR_W-1:0]   free_address,
    input  logic                         cfg_valid,
    input  logic [pba_pkg::ADDR_W-1:0]   cfg_data,
    output logic [pba_pkg::ADDR_W-1:0]   page_address,
    output logic [1:0]                   status,
    output logic                         done
);

    localparam int AW         = pba_pkg::ADDR_W;
    localparam int WB         = pba_pkg::WORD_BITS;
    localparam int BW         = pba_pkg::WORD_BIT_W;
    localparam int WORD_COUNT = (PAGE_COUNT + WB - 1) / WB;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PS_W       = $clog2(PAGE_SIZE);
    localparam int IDXF_W     = AW - PS_W;
    localparam int LAST_BITS  = PAGE_COUNT - WB * (WORD_COUNT - 1);
    // Pages past PAGE_COUNT in the last word read as taken.
    localparam logic [WB-1:0] PAD_MASK = {WB{1'b1}} << LAST_BITS;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);

    logic [AW-1:0]         base_reg;
    logic [WB-1:0]         word_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] word_valid_reg;
    logic [WORD_COUNT-1:0] full_reg;

    logic                  func_reg;
    logic                  ok_reg;
    logic [WORD_AW-1:0]    word_idx_reg;
    logic [BW-1:0]         bit_idx_reg;
    logic [WB-1:0]         rd_word_reg;
    logic                  rd_valid_reg;

    logic                  done_reg;
    logic [AW-1:0]         page_address_reg;
    logic [1:0]            status_reg;

    // capture-side lookups
    logic [WORD_AW-1:0]    alloc_word;
    logic [AW-1:0]         offset;
    logic [IDXF_W-1:0]     idx_full;
    logic                  free_ok;

    // update-side logic
    logic [WB-1:0]         word_eff;
    logic [BW-1:0]         alloc_bit;
    logic [BW-1:0]         upd_bit;
    logic [WB-1:0]         bit_mask;
    logic [WB-1:0]         new_word;
    logic [AW-1:0]         page_idx;
    logic [AW-1:0]         alloc_address;
    logic                  do_write;

    always_comb
    begin
        alloc_word = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                alloc_word = WORD_AW'(i);
            end
        end
    end

    assign offset   = free_address - base_reg;
    assign idx_full = offset[AW-1:PS_W];
    assign free_ok  = (offset[PS_W-1:0] == '0) && (idx_full < IDXF_W'(PAGE_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= pba_pkg::BASE_RESET;
        end
        else if (cfg_valid)
        begin
            base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            if (func == 1'(pba_pkg::FUNC_FREE))
            begin
                ok_reg       <= free_ok;
                word_idx_reg <= WORD_AW'(idx_full >> BW);
                bit_idx_reg  <= idx_full[BW-1:0];
            end
            else
            begin
                ok_reg       <= ~&full_reg;
                word_idx_reg <= alloc_word;
                bit_idx_reg  <= '0;
            end
        end
        if (cmd.read)
        begin
            rd_word_reg  <= word_mem[word_idx_reg];
            rd_valid_reg <= word_valid_reg[word_idx_reg];
        end
    end

    assign word_eff  = (rd_valid_reg ? rd_word_reg : '0)
                     | ((word_idx_reg == LAST_WORD) ? PAD_MASK : '0);
    assign alloc_bit = pba_pkg::first_zero(word_eff);
    assign upd_bit   = (func_reg == 1'(pba_pkg::FUNC_FREE)) ? bit_idx_reg : alloc_bit;
    assign bit_mask  = WB'(1) << upd_bit;
    assign new_word  = (func_reg == 1'(pba_pkg::FUNC_FREE)) ? (word_eff & ~bit_mask)
                                                            : (word_eff | bit_mask);
    assign page_idx  = (AW'(word_idx_reg) << BW) | AW'(alloc_bit);
    assign alloc_address = base_reg + (page_idx << PS_W);
    assign do_write  = cmd.update && ok_reg;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            word_mem[word_idx_reg] <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            full_reg       <= '0;
        end
        else if (do_write)
        begin
            word_valid_reg[word_idx_reg] <= 1'b1;
            full_reg[word_idx_reg]       <= &new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (func_reg == 1'(pba_pkg::FUNC_FREE))
            begin
                page_address_reg <= '0;
                status_reg       <= ok_reg ? pba_pkg::STATUS_OK : pba_pkg::STATUS_BAD_FREE;
            end
            else
            begin
                page_address_reg <= ok_reg ? alloc_address : '0;
                status_reg       <= ok_reg ? pba_pkg::STATUS_OK : pba_pkg::STATUS_NO_PAGE;
            end
        end
    end

    assign done         = done_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.update))
        else $error("result strobe without update");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != pba_pkg::STATUS_OK)) |-> (page_address == '0))
        else $error("failed request returned an address");

    a_no_done_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> !done)
        else $error("result strobe overlaps bitmap read");

endmodule
